### design/klv_pkg.sv
// Package with the shared constants, codes and result type of the KLV BER stream parser.
`default_nettype none
package klv_pkg;

	// Buffer positions at or beyond this count are flagged as overlong.
	localparam int MAX_BUFFER_BYTES = 65536;
	localparam int POS_W            = $clog2(MAX_BUFFER_BYTES + 1);

	// Result queue depth; one input byte can create at most two results.
	localparam int RES_DEPTH  = 4;
	localparam int RES_PTR_W  = $clog2(RES_DEPTH);
	localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

	// Result kinds.
	localparam logic [2:0] KIND_ITEM     = 3'd0;
	localparam logic [2:0] KIND_END_OK   = 3'd1;
	localparam logic [2:0] KIND_BAD_LEN  = 3'd2;
	localparam logic [2:0] KIND_TRUNC    = 3'd3;
	localparam logic [2:0] KIND_OVERLONG = 3'd4;

	// Triplet layout.
	localparam int         KEY_BYTES     = 16;
	localparam int         MAX_LEN_BYTES = 4;
	localparam logic [7:0] BER_LONG_FLAG = 8'h80;
	localparam logic [7:0] BER_LEN_MASK  = 8'h7F;

	typedef struct packed {
		logic [15:0] done_count;
		logic [15:0] value_offset;
		logic [31:0] value_length;
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [2:0]  kind;
		logic        run_end;
	} result_t;

endpackage
`default_nettype wire

### design/klv_parse_core.sv
// Parser state and the single-pass result logic for one buffer byte.
`default_nettype none
module klv_parse_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output klv_pkg::result_t      res0,
	output klv_pkg::result_t      res1,
	output logic [1:0]            nres
);
	import klv_pkg::*;

	localparam logic [2:0] PH_KEY   = 3'd0;
	localparam logic [2:0] PH_LEN   = 3'd1;
	localparam logic [2:0] PH_LONG  = 3'd2;
	localparam logic [2:0] PH_VALUE = 3'd3;
	localparam logic [2:0] PH_HALT  = 3'd4;

	logic [2:0]       phase_q, phase_d;
	logic [4:0]       hc_q, hc_d;
	logic [63:0]      ku_q, ku_d, kl_q, kl_d;
	logic [31:0]      acc_q, acc_d;
	logic [2:0]       lbl_q, lbl_d;
	logic [31:0]      vbl_q, vbl_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      vs_q, vs_d;
	logic [15:0]      items_q, items_d;
	logic [2:0]       err_q, err_d;

	logic             emit;
	logic [31:0]      emit_len;
	logic [15:0]      next_off;
	logic [6:0]       cnt;
	result_t          item_r, end_r;

	assign next_off = 16'(32'(pos_q) + 32'd1);
	assign cnt      = 7'(data_byte & BER_LEN_MASK);

	always_comb begin
		phase_d  = phase_q;
		hc_d     = hc_q;
		ku_d     = ku_q;
		kl_d     = kl_q;
		acc_d    = acc_q;
		lbl_d    = lbl_q;
		vbl_d    = vbl_q;
		pos_d    = pos_q;
		vs_d     = vs_q;
		items_d  = items_q;
		err_d    = err_q;
		emit     = 1'b0;
		emit_len = '0;
		item_r   = '0;
		end_r    = '0;
		res0     = '0;
		res1     = '0;
		nres     = 2'd0;
		if (step) begin
			if (phase_q != PH_HALT && pos_q >= POS_W'(MAX_BUFFER_BYTES)) begin
				err_d   = KIND_OVERLONG;
				phase_d = PH_HALT;
			end else begin
				unique case (phase_q)
					PH_KEY: begin
						if (hc_q < 5'd8)
							ku_d = {ku_q[55:0], data_byte};
						else
							kl_d = {kl_q[55:0], data_byte};
						hc_d = hc_q + 5'd1;
						if (hc_d >= 5'(KEY_BYTES))
							phase_d = PH_LEN;
					end
					PH_LEN: begin
						if (last_byte) begin
							phase_d = PH_KEY;
							hc_d    = '0;
						end else if ((data_byte & BER_LONG_FLAG) != 8'd0) begin
							if (cnt > 7'(MAX_LEN_BYTES)) begin
								err_d   = KIND_BAD_LEN;
								phase_d = PH_HALT;
							end else if (cnt == 7'd0) begin
								vs_d = next_off;
								emit = 1'b1;
							end else begin
								acc_d   = '0;
								lbl_d   = 3'(cnt);
								phase_d = PH_LONG;
							end
						end else begin
							vs_d = next_off;
							if (data_byte == 8'd0) begin
								emit = 1'b1;
							end else begin
								acc_d   = 32'(data_byte);
								vbl_d   = 32'(data_byte);
								phase_d = PH_VALUE;
							end
						end
					end
					PH_LONG: begin
						acc_d = {acc_q[23:0], data_byte};
						if (lbl_q != 3'd0)
							lbl_d = lbl_q - 3'd1;
						if (lbl_d == 3'd0) begin
							vs_d = next_off;
							if (acc_d == 32'd0) begin
								emit = 1'b1;
							end else begin
								vbl_d   = acc_d;
								phase_d = PH_VALUE;
							end
						end
					end
					PH_VALUE: begin
						if (vbl_q != 32'd0)
							vbl_d = vbl_q - 32'd1;
						if (vbl_d == 32'd0) begin
							emit     = 1'b1;
							emit_len = acc_q;
						end
					end
					default: begin
					end
				endcase
			end

			if (emit) begin
				if (items_q != 16'hFFFF)
					items_d = items_q + 16'd1;
				item_r.kind         = KIND_ITEM;
				item_r.key_high     = ku_d;
				item_r.key_low      = kl_d;
				item_r.value_length = emit_len;
				item_r.value_offset = vs_d;
				item_r.done_count   = items_d;
				item_r.run_end      = ~last_byte;
				res0                = item_r;
				nres                = 2'd1;
				phase_d             = PH_KEY;
				hc_d                = '0;
			end

			if (pos_q < POS_W'(MAX_BUFFER_BYTES))
				pos_d = pos_q + POS_W'(1);

			if (last_byte) begin
				if (err_d == 3'd0 && (phase_d == PH_LONG || phase_d == PH_VALUE))
					err_d = KIND_TRUNC;
				end_r.kind       = (err_d == 3'd0) ? KIND_END_OK : err_d;
				end_r.done_count = items_d;
				end_r.run_end    = 1'b1;
				if (emit)
					res1 = end_r;
				else
					res0 = end_r;
				nres    = nres + 2'd1;
				// The whole parser returns to its reset state after an end result.
				phase_d = PH_KEY;
				hc_d    = '0;
				ku_d    = '0;
				kl_d    = '0;
				acc_d   = '0;
				lbl_d   = '0;
				vbl_d   = '0;
				pos_d   = '0;
				vs_d    = '0;
				items_d = '0;
				err_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			hc_q    <= '0;
			ku_q    <= '0;
			kl_q    <= '0;
			acc_q   <= '0;
			lbl_q   <= '0;
			vbl_q   <= '0;
			pos_q   <= '0;
			vs_q    <= '0;
			items_q <= '0;
			err_q   <= '0;
		end else begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			ku_q    <= ku_d;
			kl_q    <= kl_d;
			acc_q   <= acc_d;
			lbl_q   <= lbl_d;
			vbl_q   <= vbl_d;
			pos_q   <= pos_d;
			vs_q    <= vs_d;
			items_q <= items_d;
			err_q   <= err_d;
		end
	end

	// Only the first error is kept until the buffer ends.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != 3'd0 && !(step && last_byte)) |=> err_q == $past(err_q))
		else $error("latched error code changed before the buffer ended");

	// Two results only come from an item that completes on the final byte.
	a_two_res: assert property (@(posedge clk) disable iff (!arst_n)
		(nres == 2'd2) |-> (res0.kind == KIND_ITEM && res1.run_end && last_byte))
		else $error("second result is not an end result");

	// No parsing happens while halted on an error.
	a_halt_err: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT) |-> (err_q != 3'd0))
		else $error("halted without a latched error");

endmodule
`default_nettype wire

### design/klv_result_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
`default_nettype none
module klv_result_fifo (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire klv_pkg::result_t             wr0,
	input  wire klv_pkg::result_t             wr1,
	input  wire logic [1:0]                   push_n,
	output klv_pkg::result_t                  head,
	output logic                              head_valid,
	input  wire logic                         pop,
	output logic [klv_pkg::RES_CNT_W-1:0]     free
);
	import klv_pkg::*;

	result_t                mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wp_q, rp_q;
	logic [RES_CNT_W-1:0]   count_q;

	assign head       = mem_q[rp_q];
	assign head_valid = (count_q != '0);
	assign free       = RES_CNT_W'(RES_DEPTH) - count_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wp_q] <= wr0;
		if (push_n == 2'd2)
			mem_q[wp_q + RES_PTR_W'(1)] <= wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + RES_PTR_W'(push_n);
			if (pop)
				rp_q <= rp_q + RES_PTR_W'(1);
			count_q <= count_q + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		RES_CNT_W'(push_n) <= free)
		else $error("result queue pushed beyond its free space");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue count out of range");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == 2'd0) |=> count_q == $past(count_q) - RES_CNT_W'(1))
		else $error("pop without push did not drain one entry");

endmodule
`default_nettype wire

### design/klv_ber_stream_parser.sv
// Top level of the KLV BER stream parser: input register, parser core and result queue.
`default_nettype none
// The parser takes a metadata buffer one byte per transaction on the s_axis side,
// with s_axis_tlast on the final byte, and splits it into key-length-value triplets
// made of a 16-byte key and a BER length (short form below 0x80, long form 0x80 plus
// a count of up to four big-endian length bytes). When the last value byte of a
// triplet arrives (for a zero length, its last length byte), an item result with
// the key, the decoded length and the offset of the first value byte is sent on the
// m_axis side. The final byte also produces an end result: "end ok" with the item
// count, or the first error seen (bad length form, truncated triplet, or a buffer
// longer than MAX_BUFFER_BYTES). An error end result means the items already sent
// for that buffer should be discarded. A trailing partial header of no more than
// key plus first length byte is ignored. m_axis_tlast marks the last result caused
// by one input byte. The block sustains one byte per clock cycle while the result
// queue has room: each accepted byte is registered, parsed combinationally, and its
// results go into a four-entry result queue. A byte moves from the input register
// into the parser only when the queue has room for two results. With the m_axis
// side always ready the input never stalls, since a byte yields at most two results
// and bytes that yield two are far apart; only back-pressure on the m_axis side can
// fill the queue and pull s_axis_tready low. A result is offered on the m_axis side
// once its byte has left the input register and its results are in the queue.
module klv_ber_stream_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input byte stream.
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,    // [7:0] data_byte
	input  wire logic         s_axis_tlast,    // last_byte
	// Result stream.
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [191:0]      m_axis_tdata,    // [63:0] key_high, [127:64] key_low,
	                                           // [159:128] value_length,
	                                           // [175:160] value_offset,
	                                           // [191:176] done_count
	output logic [2:0]        m_axis_tuser,    // [2:0] kind
	output logic              m_axis_tlast     // run_end
);
	import klv_pkg::*;

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 last_s1;
	logic                 step;
	logic                 in_fire;
	result_t              res0, res1, head;
	logic [1:0]           nres;
	logic [RES_CNT_W-1:0] free;
	logic                 head_valid;

	// The byte in the input register is parsed once the queue can hold
	// the worst case of two results.
	assign step          = valid_s1 && (free >= RES_CNT_W'(2));
	assign s_axis_tready = !valid_s1 || step;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	klv_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res0      (res0),
		.res1      (res1),
		.nres      (nres)
	);

	klv_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr0        (res0),
		.wr1        (res1),
		.push_n     (nres),
		.head       (head),
		.head_valid (head_valid),
		.pop        (m_axis_tvalid && m_axis_tready),
		.free       (free)
	);

	assign m_axis_tvalid = head_valid;
	assign m_axis_tdata  = {head.done_count, head.value_offset, head.value_length,
	                        head.key_low, head.key_high};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.run_end;

	// A byte held in the input register is parsed exactly once.
	a_step_once: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !in_fire) |=> !valid_s1)
		else $error("input register still valid after its byte was parsed");

	// Results appear only when a held byte is parsed.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		(nres != 2'd0) |-> step)
		else $error("results produced without a parsed byte");

	// The input register never drops a byte that has not been parsed.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && data_s1 == $past(data_s1)))
		else $error("held input byte changed before it was parsed");

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the KLV BER stream parser: directed buffers and random buffers.
`timescale 1ns / 100ps
module tb_top;
	import klv_pkg::*;

	// Parse phases of the local copy of the parser.
	typedef enum logic [2:0] {PH_KEY, PH_LEN, PH_LONG, PH_VALUE, PH_HALT} parse_phase_t;

	localparam logic [2:0] NO_ERR = 3'd0;

	// One directed buffer segment: key bytes, length bytes (first byte in the top bits),
	// then nrand random bytes. Unless cont is set, the last byte carries tlast. Where
	// typed is set, the end result's kind and count are taken from the row itself.
	typedef struct packed {
		logic [63:0] khi;
		logic [63:0] klo;
		logic [39:0] lb;
		logic [4:0]  nkey;
		logic [2:0]  nlen;
		logic [15:0] nrand;
		logic        cont;
		logic        typed;
		logic [2:0]  kind;
		logic [15:0] cnt;
	} stim_row_t;

	localparam int NUM_ROWS = 17;

	stim_row_t dir_rows [NUM_ROWS] = '{
		// Zero key, zero short length, then one stray byte.
		'{64'h0, 64'h0, 40'h00_0000_0000, 5'd16, 3'd1, 16'd1, 1'b0, 1'b1, KIND_END_OK, 16'd1},
		// All-ones key, longest short form; the final byte closes the item too.
		'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 40'h7F_0000_0000, 5'd16, 3'd1,
			16'd127, 1'b0, 1'b1, KIND_END_OK, 16'd1},
		// Long forms with zero, one, four and two length bytes inside one buffer.
		'{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 40'h80_0000_0000, 5'd16, 3'd1,
			16'd0, 1'b1, 1'b0, KIND_ITEM, 16'd0},
		'{64'h5A5A_A5A5_3C3C_C3C3, 64'h0F0F_F0F0_6969_9696, 40'h81_0500_0000, 5'd16, 3'd2,
			16'd5, 1'b1, 1'b0, KIND_ITEM, 16'd0},
		'{64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 40'h84_0000_0003, 5'd16, 3'd5,
			16'd3, 1'b1, 1'b0, KIND_ITEM, 16'd0},
		'{64'h9600_1122_3344_5566, 64'h7788_99AA_BBCC_DDEE, 40'h82_0000_0000, 5'd16, 3'd3,
			16'd1, 1'b0, 1'b1, KIND_END_OK, 16'd4},
		// Count above four is a bad length form; later bytes are ignored.
		'{64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 40'h85_0000_0000, 5'd16, 3'd1,
			16'd3, 1'b0, 1'b1, KIND_BAD_LEN, 16'd0},
		// A malformed length byte that is also the final byte is only a short tail.
		'{64'hDEAD_BEEF_CAFE_F00D, 64'h0BAD_F00D_1234_5678, 40'hFF_0000_0000, 5'd16, 3'd1,
			16'd0, 1'b0, 1'b1, KIND_END_OK, 16'd0},
		// Short tails: a few key bytes, and a single-byte buffer.
		'{64'hA1A2_A3A4_A5A6_A7A8, 64'h0, 40'h0, 5'd5, 3'd0, 16'd0, 1'b0, 1'b1, KIND_END_OK,
			16'd0},
		'{64'h0, 64'h0, 40'h0, 5'd0, 3'd0, 16'd1, 1'b0, 1'b1, KIND_END_OK, 16'd0},
		// Buffer ends inside the long-form length bytes, then inside the value.
		'{64'h2468_ACE0_1357_9BDF, 64'hFDB9_7531_0ECA_8642, 40'h84_0100_0000, 5'd16, 3'd2,
			16'd0, 1'b0, 1'b1, KIND_TRUNC, 16'd0},
		'{64'hC001_D00D_FEED_FACE, 64'h1234_4321_ABCD_DCBA, 40'h10_0000_0000, 5'd16, 3'd1,
			16'd4, 1'b0, 1'b1, KIND_TRUNC, 16'd0},
		// One good item, then a bad form: the error replaces the end ok.
		'{64'h0102_0304_0506_0708, 64'h090A_0B0C_0D0E_0F10, 40'h01_0000_0000, 5'd16, 3'd1,
			16'd1, 1'b1, 1'b0, KIND_ITEM, 16'd0},
		'{64'hF0E0_D0C0_B0A0_9080, 64'h7060_5040_3020_1000, 40'h87_0000_0000, 5'd16, 3'd1,
			16'd2, 1'b0, 1'b1, KIND_BAD_LEN, 16'd1},
		// Largest possible decoded length, cut short.
		'{64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF, 40'h84_FFFF_FFFF, 5'd16, 3'd5,
			16'd2, 1'b0, 1'b1, KIND_TRUNC, 16'd0},
		// Two length bytes, 128 value bytes, final byte on the last value byte.
		'{64'h3141_5926_5358_9793, 64'h2384_6264_3383_2795, 40'h82_0080_0000, 5'd16, 3'd3,
			16'd128, 1'b0, 1'b0, KIND_ITEM, 16'd0},
		// Zero short length on the final byte: the triplet is dropped.
		'{64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0, 40'h00_0000_0000, 5'd16, 3'd1,
			16'd0, 1'b0, 1'b1, KIND_END_OK, 16'd0}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [191:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         m_axis_tlast;

	// Local copy of the parser state.
	parse_phase_t       ph;
	int unsigned        key_bytes_seen;
	logic [63:0]        key_hi_acc;
	logic [63:0]        key_lo_acc;
	logic [31:0]        len_acc;
	int unsigned        len_bytes_due;
	logic [31:0]        val_bytes_due;
	logic [POS_W-1:0]   buf_pos;
	logic [15:0]        val_offset;
	logic [15:0]        items_in_buf;
	logic [2:0]         latched_err;

	result_t step_res [0:1];
	int      step_n;
	result_t klv_results_due [$];

	bit          end_typed = 1'b0;
	logic [2:0]  end_kind_typed;
	logic [15:0] end_count_typed;

	int mismatches = 0;
	int burst_left = 0;
	int bytes_sent = 0;
	bit hold_req = 1'b0;

	always #5 clk = ~clk;

	klv_ber_stream_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	task automatic clear_parser();
		ph = PH_KEY;
		key_bytes_seen = 0;
		key_hi_acc = '0;
		key_lo_acc = '0;
		len_acc = '0;
		len_bytes_due = 0;
		val_bytes_due = '0;
		buf_pos = '0;
		val_offset = '0;
		items_in_buf = '0;
		latched_err = NO_ERR;
	endtask

	// A triplet is complete: queue its item and start looking for the next key.
	task automatic close_triplet(input logic [31:0] vlen);
		if (items_in_buf != 16'hFFFF) begin
			items_in_buf++;
		end
		step_res[step_n] = '0;
		step_res[step_n].kind = KIND_ITEM;
		step_res[step_n].key_high = key_hi_acc;
		step_res[step_n].key_low = key_lo_acc;
		step_res[step_n].value_length = vlen;
		step_res[step_n].value_offset = val_offset;
		step_res[step_n].done_count = items_in_buf;
		step_n++;
		ph = PH_KEY;
		key_bytes_seen = 0;
	endtask

	// Advances the local parser by one accepted byte and queues the results it causes.
	task automatic parse_klv_byte(input logic [7:0] b, input logic is_last);
		logic [POS_W-1:0] at;
		logic [6:0]       cnt;
		at = buf_pos;
		step_n = 0;
		if (ph != PH_HALT && at >= MAX_BUFFER_BYTES) begin
			latched_err = KIND_OVERLONG;
			ph = PH_HALT;
		end else begin
			case (ph)
				PH_KEY: begin
					if (key_bytes_seen < 8) begin
						key_hi_acc = {key_hi_acc[55:0], b};
					end else begin
						key_lo_acc = {key_lo_acc[55:0], b};
					end
					key_bytes_seen++;
					if (key_bytes_seen >= KEY_BYTES) begin
						ph = PH_LEN;
					end
				end
				PH_LEN: begin
					cnt = b[6:0] & BER_LEN_MASK[6:0];
					if (is_last) begin
						// Key plus first length byte not followed by anything: dropped.
						ph = PH_KEY;
						key_bytes_seen = 0;
					end else if ((b & BER_LONG_FLAG) != 0) begin
						if (cnt > MAX_LEN_BYTES) begin
							latched_err = KIND_BAD_LEN;
							ph = PH_HALT;
						end else if (cnt == 0) begin
							val_offset = 16'(at + 1);
							close_triplet(32'd0);
						end else begin
							len_acc = '0;
							len_bytes_due = int'(cnt);
							ph = PH_LONG;
						end
					end else begin
						val_offset = 16'(at + 1);
						if (b == 8'd0) begin
							close_triplet(32'd0);
						end else begin
							len_acc = {24'd0, b};
							val_bytes_due = {24'd0, b};
							ph = PH_VALUE;
						end
					end
				end
				PH_LONG: begin
					len_acc = {len_acc[23:0], b};
					if (len_bytes_due > 0) begin
						len_bytes_due--;
					end
					if (len_bytes_due == 0) begin
						val_offset = 16'(at + 1);
						if (len_acc == 0) begin
							close_triplet(32'd0);
						end else begin
							val_bytes_due = len_acc;
							ph = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					if (val_bytes_due > 0) begin
						val_bytes_due--;
					end
					if (val_bytes_due == 0) begin
						close_triplet(len_acc);
					end
				end
				default: begin
				end
			endcase
		end

		if (buf_pos < MAX_BUFFER_BYTES) begin
			buf_pos++;
		end

		if (is_last) begin
			if (latched_err == NO_ERR && (ph == PH_LONG || ph == PH_VALUE)) begin
				latched_err = KIND_TRUNC;
			end
			step_res[step_n] = '0;
			step_res[step_n].kind = (latched_err == NO_ERR) ? KIND_END_OK : latched_err;
			step_res[step_n].done_count = items_in_buf;
			if (end_typed) begin
				step_res[step_n].kind = end_kind_typed;
				step_res[step_n].done_count = end_count_typed;
			end
			step_n++;
			clear_parser();
		end

		if (step_n > 0) begin
			step_res[step_n - 1].run_end = 1'b1;
		end
		for (int k = 0; k < step_n; k++) begin
			klv_results_due.push_back(step_res[k]);
		end
	endtask

	// Offers one byte, in bursts separated by idle gaps. Called and returns at a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 25);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		parse_klv_byte(b, is_last);
		burst_left--;
		bytes_sent++;
		@(negedge clk);
	endtask

	// Sends nkey key bytes, nlen length bytes and nrand random bytes, in that order.
	task automatic send_segment(input logic [127:0] key, input logic [39:0] lb, input int nkey,
			input int nlen, input int nrand, input bit ends);
		int         total;
		logic [7:0] b;
		total = nkey + nlen + nrand;
		for (int k = 0; k < total; k++) begin
			if (k < nkey) begin
				b = key[127 - 8 * k -: 8];
			end else if (k < nkey + nlen) begin
				b = lb[39 - 8 * (k - nkey) -: 8];
			end else begin
				b = 8'($urandom);
			end
			send_byte(b, ends && k == total - 1);
		end
	endtask

	task automatic flag_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	// Result checker: every transaction on the result side is matched against the oldest
	// expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (klv_results_due.size() == 0) begin
				flag_mismatch("unexpected result, kind", 64'd0, {61'd0, m_axis_tuser});
			end else begin
				want = klv_results_due.pop_front();
				if (m_axis_tuser !== want.kind)
					flag_mismatch("kind", want.kind, m_axis_tuser);
				if (m_axis_tdata[63:0] !== want.key_high)
					flag_mismatch("key_high", want.key_high, m_axis_tdata[63:0]);
				if (m_axis_tdata[127:64] !== want.key_low)
					flag_mismatch("key_low", want.key_low, m_axis_tdata[127:64]);
				if (m_axis_tdata[159:128] !== want.value_length)
					flag_mismatch("value_length", want.value_length, m_axis_tdata[159:128]);
				if (m_axis_tdata[175:160] !== want.value_offset)
					flag_mismatch("value_offset", want.value_offset, m_axis_tdata[175:160]);
				if (m_axis_tdata[191:176] !== want.done_count)
					flag_mismatch("done_count", want.done_count, m_axis_tdata[191:176]);
				if (m_axis_tlast !== want.run_end)
					flag_mismatch("run_end", want.run_end, m_axis_tlast);
			end
		end
	end

	// Result side back-pressure: segments of always ready, random stalls and a slow
	// periodic pattern, plus one long hold-off on request so that the block fills up.
	initial begin
		int seg_left;
		int mode;
		seg_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (299) @(negedge clk);
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 2);
					seg_left = $urandom_range(10, 80);
				end
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					default: m_axis_tready <= (seg_left % 3 == 0);
				endcase
				seg_left--;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		stim_row_t   row;
		int          ntrip;
		int          ending;
		int          c;
		int          nl;
		int          vlen;
		logic [39:0] lb;
		logic [127:0] key;

		clear_parser();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = dir_rows[i];
			end_typed = row.typed;
			end_kind_typed = row.kind;
			end_count_typed = row.cnt;
			send_segment({row.khi, row.klo}, row.lb, row.nkey, row.nlen, row.nrand, !row.cont);
		end
		end_typed = 1'b0;

		// Random buffers: mostly well-formed triplets, each buffer closed cleanly or by one
		// of the broken endings.
		hold_req = 1'b1;
		while (bytes_sent < 900) begin
			ntrip = $urandom_range(0, 4);
			ending = $urandom_range(0, 9);
			if (ntrip == 0 && ending < 5) begin
				ending = 9;
			end
			for (int t = 0; t < ntrip; t++) begin
				key = {$urandom, $urandom, $urandom, $urandom};
				if ($urandom_range(0, 2) != 0) begin
					vlen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
					lb = {8'(vlen), 32'h0};
					nl = 1;
				end else begin
					c = $urandom_range(0, MAX_LEN_BYTES);
					vlen = (c == 0) ? 0 : $urandom_range(0, 40);
					lb = {BER_LONG_FLAG | 8'(c), 32'(vlen) << (8 * (MAX_LEN_BYTES - c))};
					nl = 1 + c;
				end
				send_segment(key, lb, KEY_BYTES, nl, vlen, ending < 5 && t == ntrip - 1);
			end
			key = {$urandom, $urandom, $urandom, $urandom};
			case (ending)
				5, 6: begin
					// Trailing partial header.
					nl = $urandom_range(1, KEY_BYTES);
					send_segment(key, {8'($urandom), 32'h0}, nl, (nl == KEY_BYTES) ? 1 : 0,
						0, 1'b1);
				end
				7: begin
					lb = {BER_LONG_FLAG | 8'($urandom_range(MAX_LEN_BYTES + 1, BER_LEN_MASK)),
						32'($urandom)};
					send_segment(key, lb, KEY_BYTES, 1, $urandom_range(0, 4), 1'b1);
				end
				8: begin
					// Long form with random length bytes, cut inside the length or the value.
					c = $urandom_range(1, MAX_LEN_BYTES);
					lb = {BER_LONG_FLAG | 8'(c), 32'($urandom)};
					nl = $urandom_range(1, c + 1);
					send_segment(key, lb, KEY_BYTES, nl, (nl == c + 1) ? $urandom_range(0, 10) : 0,
						1'b1);
				end
				9: begin
					send_segment(key, 40'h0, 0, 0, $urandom_range(1, 40), 1'b1);
				end
				default: begin
				end
			endcase
		end

		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		while (klv_results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
